FILE: rtl/ps2k_pkg.sv
// Shared types, constants and scancode tables for the scancode-to-key FIFO.
package ps2k_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;

    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

    localparam int NUM_KEYS   = 58;

    localparam logic [7:0] SC_EXTEND   = 8'hE0;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_CTRL     = 7'h1D;
    localparam logic [6:0] SC_CAPS     = 7'h3A;
    localparam logic [6:0] SC_UP       = 7'h48;
    localparam logic [6:0] SC_DOWN     = 7'h50;
    localparam logic [6:0] SC_LEFT     = 7'h4B;
    localparam logic [6:0] SC_RIGHT    = 7'h4D;
    localparam logic [6:0] SC_HOME     = 7'h47;
    localparam logic [6:0] SC_END      = 7'h4F;
    localparam logic [6:0] SC_DELETE   = 7'h53;
    localparam logic [6:0] SC_PGUP     = 7'h49;
    localparam logic [6:0] SC_PGDN     = 7'h51;

    localparam logic [8:0] CODE_UP     = 9'd256;
    localparam logic [8:0] CODE_DOWN   = 9'd257;
    localparam logic [8:0] CODE_LEFT   = 9'd258;
    localparam logic [8:0] CODE_RIGHT  = 9'd259;
    localparam logic [8:0] CODE_HOME   = 9'd260;
    localparam logic [8:0] CODE_END    = 9'd261;
    localparam logic [8:0] CODE_DEL    = 9'd262;
    localparam logic [8:0] CODE_PAGEUP = 9'd263;
    localparam logic [8:0] CODE_PAGEDN = 9'd264;

    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;

    typedef enum logic {
        OP_PUSH,
        OP_POP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [8:0] code;
    } key_op_t;

    localparam logic [7:0] TAB_LOWER [NUM_KEYS] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] TAB_UPPER [NUM_KEYS] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    function automatic logic is_alpha_char(input logic [7:0] c);
        is_alpha_char = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

FILE: rtl/ps2k_front.sv
// Front end: accepts transactions, tracks modifier state and decodes scancodes into ops.
module ps2k_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              opq_full,
    output logic              op_valid,
    output ps2k_pkg::key_op_t op_data
);
    import ps2k_pkg::*;

    logic       shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic       caps_reg, caps_next;
    logic       ext_reg, ext_next;
    logic       accept;
    logic       push;
    logic [8:0] push_code;
    logic       rel;
    logic [6:0] k;
    logic [7:0] c;

    assign s_tready = !opq_full;
    assign accept   = s_tvalid && s_tready;
    assign rel      = s_tdata[7];
    assign k        = s_tdata[6:0];

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        ext_next   = ext_reg;
        push       = 1'b0;
        push_code  = '0;
        c          = '0;
        if (s_tdata == SC_EXTEND)
        begin
            ext_next = 1'b1;
        end
        else if (ext_reg)
        begin
            ext_next = 1'b0;
            if (k == SC_CTRL)
            begin
                ctrl_next = !rel;
            end
            else if (!rel)
            begin
                push = 1'b1;
                case (k)
                    SC_UP:     push_code = CODE_UP;
                    SC_DOWN:   push_code = CODE_DOWN;
                    SC_LEFT:   push_code = CODE_LEFT;
                    SC_RIGHT:  push_code = CODE_RIGHT;
                    SC_HOME:   push_code = CODE_HOME;
                    SC_END:    push_code = CODE_END;
                    SC_DELETE: push_code = CODE_DEL;
                    SC_PGUP:   push_code = CODE_PAGEUP;
                    SC_PGDN:   push_code = CODE_PAGEDN;
                    default:   push      = 1'b0;
                endcase
            end
        end
        else if ((k == SC_LSHIFT) || (k == SC_RSHIFT))
        begin
            shift_next = !rel;
        end
        else if (k == SC_CTRL)
        begin
            ctrl_next = !rel;
        end
        else if (k == SC_CAPS)
        begin
            if (!rel)
            begin
                caps_next = !caps_reg;
            end
        end
        else if (!rel && (k < 7'(NUM_KEYS)))
        begin
            c = shift_reg ? TAB_UPPER[k[5:0]] : TAB_LOWER[k[5:0]];
            if (caps_reg && is_alpha_char(c))
            begin
                c = c ^ CASE_BIT;
            end
            if (ctrl_reg && is_alpha_char(c))
            begin
                c = (c | CASE_BIT) - CHAR_LOW_A + 8'd1;
            end
            push      = (c != 8'h00);
            push_code = {1'b0, c};
        end
    end

    always_comb
    begin
        op_valid     = 1'b0;
        op_data.kind = OP_PUSH;
        op_data.code = push_code;
        if (accept)
        begin
            if (s_tuser[0])
            begin
                op_valid     = 1'b1;
                op_data.kind = OP_POP;
            end
            else
            begin
                op_valid = push;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
            ext_reg   <= 1'b0;
        end
        else if (accept && !s_tuser[0])
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

FILE: rtl/ps2k_opq.sv
// Short op queue between the decoder front end and the key FIFO back end.
module ps2k_opq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  ps2k_pkg::key_op_t wr_data,
    output logic              full,
    output logic              rd_valid,
    output ps2k_pkg::key_op_t rd_data,
    input  logic              rd_take
);
    import ps2k_pkg::*;

    key_op_t              entry_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_take && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/ps2k_back.sv
// Back end: key FIFO memory with pointers and the registered result stage.
module ps2k_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  ps2k_pkg::key_op_t op_data,
    output logic              op_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [0:0]        m_tuser
);
    import ps2k_pkg::*;

    logic [8:0]       key_store [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg, out_hit_next;
    logic [8:0]       rdata_reg;
    logic             is_pop;
    logic             do_push;
    logic             do_pop;
    logic             fifo_empty;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_empty = (rd_ptr_reg == wr_ptr_reg);
    assign is_pop     = (op_data.kind == OP_POP);
    assign op_take    = op_valid && (!is_pop || !out_valid_reg || m_tready);
    assign do_push    = op_take && !is_pop && (wr_ptr_inc != rd_ptr_reg);
    assign do_pop     = op_take && is_pop && !fifo_empty;

    always_comb
    begin
        wr_ptr_next    = do_push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next    = do_pop ? rd_ptr_inc : rd_ptr_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        if (op_take && is_pop)
        begin
            out_valid_next = 1'b1;
            out_hit_next   = !fifo_empty;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            key_store[wr_ptr_reg] <= op_data.code;
        end
        if (do_pop)
        begin
            rdata_reg <= key_store[rd_ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {7'd0, (out_hit_reg ? rdata_reg : 9'd0)};

endmodule

FILE: rtl/ps2_scancode_to_key_fifo.sv
// Top level of the scancode set 1 decoder with its key FIFO.
//
//   Channel | Direction | tdata                 | tuser
//   s_      | in        | [7:0] scan_byte       | [0] cmd (0 byte, 1 read key)
//   m_      | out       | [8:0] key_code, zeros | [0] key_valid
//
// One input transaction is accepted every cycle while the op queue has room.
// A read's result passes the op queue entry and then the registered read of the
// key memory before it is offered. Reset clears the modifier flags, the op
// queue and the FIFO pointers; the key memory itself is not cleared. A stalled
// output holds its result and the next read waits at the head of the op queue,
// while the rest of the four-entry op queue fills behind it.
module ps2_scancode_to_key_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] key_code, [15:9] zero
    output logic [0:0]  m_tuser    // [0] key_valid
);
    import ps2k_pkg::*;

    logic    fe_valid;
    key_op_t fe_op;
    logic    q_full;
    logic    q_valid;
    key_op_t q_op;
    logic    q_take;

    ps2k_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .opq_full (q_full),
        .op_valid (fe_valid),
        .op_data  (fe_op)
    );

    ps2k_opq u_opq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_data  (fe_op),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_op),
        .rd_take  (q_take)
    );

    ps2k_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op_data  (q_op),
        .op_take  (q_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/ps2k_checker.sv
// Port-level checker for the scancode-to-key FIFO and its bind statement.
module ps2k_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An empty read reports key code zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("empty read with nonzero key code");

    // Key codes never exceed the last extended code.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:9] == 7'd0 && (!m_tdata[8] || m_tdata[7:0] <= 8'd8))
        else $error("key code out of range");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind ps2_scancode_to_key_fifo ps2k_checker u_ps2k_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
